@@ rtl/pulse_template_accumulator_core_macros.svh @@
// assertion macros for the pulse template accumulator
// no dependencies; included by files that carry concurrent assertions
`ifndef PULSE_TEMPLATE_ACCUMULATOR_CORE_MACROS_SVH
`define PULSE_TEMPLATE_ACCUMULATOR_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pta_pkg.sv @@
// shared types, sizes and template table builder for the pulse template accumulator
// no dependencies
package pta_pkg;

    // sizing
    localparam int NUM_CHANNELS     = 4;
    localparam int NUM_SAMPLES      = 4096;
    localparam int SAMPLE_PERIOD_NS = 2;
    localparam int PULSE_LEN        = 2000;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int CHAN_W  = 2;
    localparam int TIME_W  = 20;
    localparam int COUNT_W = 16;
    localparam int IDX_W   = 12;
    localparam int ADC_W   = 15;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 1;

    // accumulator memory
    localparam int ACC_W   = 40;
    localparam int DEPTH   = NUM_CHANNELS * NUM_SAMPLES;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SMP_W   = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;

    // template
    localparam int TMPL_W  = 14;
    localparam int K_W     = (PULSE_LEN > 1) ? $clog2(PULSE_LEN) : 1;
    localparam int LEN_W   = ($clog2(NUM_SAMPLES + 1) > $clog2(PULSE_LEN + 1)) ?
                             $clog2(NUM_SAMPLES + 1) : $clog2(PULSE_LEN + 1);
    localparam int PROD_W  = COUNT_W + TMPL_W;

    // template shape: gain 0.203, decay 0.00205 per ns, zero up to 250 ns
    localparam int GAIN_PER_MILLE  = 203;
    localparam int DECAY_PER_MEGA  = 2050;
    localparam int THRESH_NS       = 250;
    localparam int TAYLOR_TERMS    = 12;

    // readout rounding and clip
    localparam int FRAC_W   = 16;
    localparam int ADC_MAX  = 32767;

    // default window
    localparam logic signed [TIME_W-1:0] WIN_BEGIN_RST = '0;
    localparam logic signed [TIME_W-1:0] WIN_END_RST   = TIME_W'(8192);

    // item operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_BEGIN = 1'd0,
        CFG_WIN_END   = 1'd1
    } t_cfg_idx;

    typedef logic [TMPL_W-1:0] t_tmpl_rom [PULSE_LEN];

    // fixed-point exponential template, evaluated at elaboration
    function automatic t_tmpl_rom build_template();
        t_tmpl_rom   rom;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] d;
        logic [63:0] g;
        x    = ((64'(DECAY_PER_MEGA) * 64'(SAMPLE_PERIOD_NS)) << 32) / 64'(1000000);
        term = 64'(1) << 32;
        d    = term;
        g    = (64'(GAIN_PER_MILLE) << 32) / 64'(1000);
        // per-sample decay factor as a truncated series
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = ((term * x) >> 32) / 64'(k);
            if ((k % 2) != 0) begin
                d = d - term;
            end else begin
                d = d + term;
            end
        end
        for (int t = 0; t < PULSE_LEN; t++) begin
            if (t * SAMPLE_PERIOD_NS > THRESH_NS) begin
                rom[t] = TMPL_W'((g + 64'h8000) >> 16);
            end else begin
                rom[t] = '0;
            end
            g = (g * d) >> 32;
        end
        return rom;
    endfunction

endpackage

@@ rtl/pta_in_if.sv @@
// request channel of the pulse template accumulator
// depends on pta_pkg for field widths
interface pta_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [pta_pkg::FUNC_W-1:0]             func;
    logic [pta_pkg::CHAN_W-1:0]             channel;
    logic signed [pta_pkg::TIME_W-1:0]      arrival_ns;
    logic [pta_pkg::COUNT_W-1:0]            photon_count;
    logic [pta_pkg::IDX_W-1:0]              sample_index;

    modport source (
        output valid, func, channel, arrival_ns, photon_count, sample_index,
        input  ready
    );
    modport sink (
        input  valid, func, channel, arrival_ns, photon_count, sample_index,
        output ready
    );
endinterface

@@ rtl/pta_out_if.sv @@
// result channel of the pulse template accumulator
// depends on pta_pkg for field widths
interface pta_out_if;
    logic                          valid;
    logic                          ready;
    logic [pta_pkg::ADC_W-1:0]     adc_value;
    logic [pta_pkg::IDX_W-1:0]     sample_echo;

    modport source (
        output valid, adc_value, sample_echo,
        input  ready
    );
    modport sink (
        input  valid, adc_value, sample_echo,
        output ready
    );
endinterface

@@ rtl/pulse_template_accumulator_core.sv @@
// top level: per-channel waveform accumulators built from a pulse template
// depends on pta_pkg, pta_in_if, pta_out_if and the assertion macro header
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+-------------------------------------------
//  i_in      | in  | valid / ready    | func, channel, arrival_ns, photon_count,
//            |     |                  | sample_index
//  o_out     | out | valid / ready    | adc_value, sample_echo
//  i_cfg_*   | in  | we, no wait      | index, data (window begin / end)
//
// an add walks the template through the accumulator memory, one entry per cycle, over
// len = min(2000, 4096 - bin) entries; the single memory port pair carries the
// read-modify-write pipeline, which drains before the next item is taken
// a clear sweeps all 4096 entries of its channel; a read waits for a free output slot
// after reset all 16384 memory entries are zeroed before any item is taken
// a result waits in the output register while the next item is taken
`include "pulse_template_accumulator_core_macros.svh"

module pulse_template_accumulator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    pta_in_if.sink                               i_in,
    pta_out_if.source                            o_out,
    input  logic                                 i_cfg_we,
    input  logic [pta_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pta_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int ADDR_W = pta_pkg::ADDR_W;
    localparam int ACC_W  = pta_pkg::ACC_W;
    localparam int K_W    = pta_pkg::K_W;
    localparam int SMP_W  = pta_pkg::SMP_W;
    localparam int LEN_W  = pta_pkg::LEN_W;
    localparam int TIME_W = pta_pkg::TIME_W;
    localparam int PROD_W = pta_pkg::PROD_W;
    localparam int DIFF_W = TIME_W + 1;
    localparam int RND_W  = ACC_W + 1;
    localparam int FRAC_SHIFT = pta_pkg::FRAC_W;

    localparam pta_pkg::t_tmpl_rom TMPL_ROM = pta_pkg::build_template();

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_CLEAR, ST_WIN, ST_LEN, ST_ADD, ST_DRAIN, ST_READ, ST_RESP
    } t_state;

    // registers
    t_state                             r_state;
    logic signed [TIME_W-1:0]           r_win_begin;
    logic signed [TIME_W-1:0]           r_win_end;
    logic [ADDR_W-1:0]                  r_addr;
    logic [ADDR_W-1:0]                  r_end;
    logic [ADDR_W-1:0]                  r_base;
    logic [K_W-1:0]                     r_k;
    logic [K_W-1:0]                     r_len_m1;
    logic [SMP_W-1:0]                   r_bin;
    logic signed [TIME_W-1:0]           r_arrival;
    logic [pta_pkg::COUNT_W-1:0]        r_count;
    logic [pta_pkg::IDX_W-1:0]          r_idx;
    logic                               r_ok;
    logic                               r_out_valid;
    logic [pta_pkg::ADC_W-1:0]          r_adc;
    logic [pta_pkg::IDX_W-1:0]          r_echo;

    // memory and pipeline
    logic [ACC_W-1:0]                   r_mem [pta_pkg::DEPTH];
    logic [ACC_W-1:0]                   r_mem_q;
    logic [pta_pkg::TMPL_W-1:0]         r_rom_q;
    logic                               r_s1_v;
    logic [ADDR_W-1:0]                  r_s1_addr;
    logic                               r_s2_v;
    logic [ADDR_W-1:0]                  r_s2_addr;
    logic [ACC_W-1:0]                   r_s2_acc;
    logic [PROD_W-1:0]                  r_s2_prod;

    // combinational values
    logic                               n_accept;
    logic                               n_ch_ok;
    logic [ADDR_W-1:0]                  n_base;
    logic signed [DIFF_W-1:0]           n_diff;
    logic [DIFF_W-1:0]                  n_bin;
    logic                               n_in_win;
    logic [LEN_W-1:0]                   n_rem;
    logic [LEN_W-1:0]                   n_len;
    logic [RND_W-1:0]                   n_sum;
    logic [ACC_W-1:0]                   n_sat;
    logic [RND_W-1:0]                   n_rnd;
    logic [RND_W-FRAC_SHIFT-1:0]        n_whole;
    logic [pta_pkg::ADC_W-1:0]          n_adc;
    logic                               n_slot_free;
    logic                               n_we;
    logic [ADDR_W-1:0]                  n_waddr;
    logic [ACC_W-1:0]                   n_wdata;

    // handshakes
    assign i_in.ready        = (r_state == ST_IDLE);
    assign n_accept          = i_in.valid && i_in.ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.adc_value   = r_adc;
    assign o_out.sample_echo = r_echo;
    assign n_slot_free       = !r_out_valid || o_out.ready;

    // request decode
    assign n_ch_ok = (32'(i_in.channel) < pta_pkg::NUM_CHANNELS);
    assign n_base  = ADDR_W'(ADDR_W'(i_in.channel) * ADDR_W'(pta_pkg::NUM_SAMPLES));

    // window check and bin of arrival time
    assign n_diff   = DIFF_W'(r_arrival) - DIFF_W'(r_win_begin);
    assign n_in_win = (r_arrival > r_win_begin) && (r_arrival < r_win_end);
    assign n_bin    = DIFF_W'($unsigned(n_diff) / DIFF_W'(pta_pkg::SAMPLE_PERIOD_NS));

    // pulse length cut at the buffer end
    assign n_rem = LEN_W'(pta_pkg::NUM_SAMPLES) - LEN_W'(r_bin);
    assign n_len = (n_rem < LEN_W'(pta_pkg::PULSE_LEN)) ? n_rem : LEN_W'(pta_pkg::PULSE_LEN);

    // accumulate with saturation
    assign n_sum = RND_W'(r_s2_acc) + RND_W'(r_s2_prod);
    assign n_sat = n_sum[ACC_W] ? {ACC_W{1'b1}} : n_sum[ACC_W-1:0];

    // readout rounding half-up and clip
    assign n_rnd   = RND_W'(r_mem_q) + (RND_W'(1) << (FRAC_SHIFT - 1));
    assign n_whole = n_rnd[RND_W-1:FRAC_SHIFT];
    assign n_adc   = !r_ok ? '0 :
                     (n_whole > (RND_W-FRAC_SHIFT)'(pta_pkg::ADC_MAX)) ?
                     pta_pkg::ADC_W'(pta_pkg::ADC_MAX) : n_whole[pta_pkg::ADC_W-1:0];

    // memory write select: sweeps write zero, else the pipeline writes back
    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_s2_addr;
        n_wdata = n_sat;
        if (r_state == ST_INIT || r_state == ST_CLEAR) begin
            n_we    = 1'b1;
            n_waddr = r_addr;
            n_wdata = '0;
        end else if (r_s2_v) begin
            n_we = 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_begin <= pta_pkg::WIN_BEGIN_RST;
            r_win_end   <= pta_pkg::WIN_END_RST;
        end else if (i_cfg_we) begin
            unique case (pta_pkg::t_cfg_idx'(i_cfg_index))
                pta_pkg::CFG_WIN_BEGIN: r_win_begin <= $signed(i_cfg_data[TIME_W-1:0]);
                pta_pkg::CFG_WIN_END:   r_win_end   <= $signed(i_cfg_data[TIME_W-1:0]);
                default: ;
            endcase
        end
    end

    // accumulator memory and template rom, registered reads
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        r_mem_q <= r_mem[r_addr];
        r_rom_q <= TMPL_ROM[r_k];
    end

    // read-modify-write pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= (r_state == ST_ADD);
            r_s2_v <= r_s1_v;
        end
        r_s1_addr <= r_addr;
        r_s2_addr <= r_s1_addr;
        r_s2_acc  <= r_mem_q;
        r_s2_prod <= PROD_W'(r_count) * PROD_W'(r_rom_q);
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_addr      <= '0;
            r_end       <= ADDR_W'(pta_pkg::DEPTH - 1);
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_INIT, ST_CLEAR: begin
                    r_addr <= r_addr + ADDR_W'(1);
                    if (r_addr == r_end) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (n_accept) begin
                        r_arrival <= i_in.arrival_ns;
                        r_count   <= i_in.photon_count;
                        r_idx     <= i_in.sample_index;
                        r_base    <= n_base;
                        unique case (pta_pkg::t_func'(i_in.func))
                            pta_pkg::FUNC_CLEAR: begin
                                r_addr <= n_base;
                                r_end  <= n_base + ADDR_W'(pta_pkg::NUM_SAMPLES - 1);
                                if (n_ch_ok) begin
                                    r_state <= ST_CLEAR;
                                end
                            end
                            pta_pkg::FUNC_ADD: begin
                                if (n_ch_ok) begin
                                    r_state <= ST_WIN;
                                end
                            end
                            pta_pkg::FUNC_READ: begin
                                r_addr  <= n_base + ADDR_W'(i_in.sample_index);
                                r_ok    <= n_ch_ok && (32'(i_in.sample_index) <
                                                       pta_pkg::NUM_SAMPLES);
                                r_state <= ST_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WIN: begin
                    r_bin <= n_bin[SMP_W-1:0];
                    if (n_in_win && (n_bin < DIFF_W'(pta_pkg::NUM_SAMPLES))) begin
                        r_state <= ST_LEN;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_LEN: begin
                    r_addr   <= r_base + ADDR_W'(r_bin);
                    r_k      <= '0;
                    r_len_m1 <= K_W'(n_len - LEN_W'(1));
                    r_state  <= ST_ADD;
                end
                ST_ADD: begin
                    r_addr <= r_addr + ADDR_W'(1);
                    r_k    <= r_k + K_W'(1);
                    if (r_k == r_len_m1) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_k <= '0;
                    if (!r_s1_v && !r_s2_v) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_READ: begin
                    r_state <= ST_RESP;
                end
                ST_RESP: begin
                    if (n_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_adc       <= n_adc;
                        r_echo      <= r_idx;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // checks
    `PTA_ASSERT_NOW(a_idle_pipe_empty, i_clk, i_rst_n, i_in.ready,
        !r_s1_v && !r_s2_v, "item taken while writebacks are pending")
    `PTA_ASSERT_NOW(a_wb_only_in_add, i_clk, i_rst_n, r_s2_v,
        r_state == ST_ADD || r_state == ST_DRAIN, "writeback outside an add")
    `PTA_ASSERT_NOW(a_k_in_range, i_clk, i_rst_n, r_state == ST_ADD,
        r_k <= r_len_m1, "template index past pulse length")
    `PTA_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, r_state == ST_RESP && n_slot_free,
        r_out_valid && r_state == ST_IDLE, "read result not presented")

endmodule
